### rtl/core/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants of the sensor frame deframer
// Frame delimiter bytes, controller state encoding and the command/status
// bundles that join the controller and the datapath.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Default payload buffer depth in bytes
  localparam int unsigned MaxPayloadDef = 32;

  // Frame delimiters
  localparam logic [7:0] Hdr0 = 8'hFF;
  localparam logic [7:0] Hdr1 = 8'hEE;
  localparam logic [7:0] Hdr2 = 8'hDD;
  localparam logic [7:0] Ftr0 = 8'hDD;
  localparam logic [7:0] Ftr1 = 8'hEE;
  localparam logic [7:0] Ftr2 = 8'hFF;

  // Output field widths
  localparam int unsigned CountW = 6;
  localparam int unsigned IndexW = 5;

  typedef enum logic [3:0] {
    S_H0,
    S_H1,
    S_H2,
    S_LEN_HI,
    S_LEN_LO,
    S_CMD,
    S_PAYLOAD,
    S_CSUM,
    S_F0,
    S_F1,
    S_F2,
    S_RD,
    S_OUT
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic len_hi_load;
    logic len_lo_load;
    logic cmd_load;
    logic pay_write;
    logic csum_load;
    logic rd_clear;
    logic rd_issue;
    logic rd_advance;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_ff;
    logic is_ee;
    logic is_dd;
    logic len_ok;
    logic count_zero;
    logic pay_done;
    logic out_last;
  } status_t;

endpackage

### rtl/core/sensor_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_deframer_core: length-prefixed frame deframer
// Hunts for FF EE DD, takes a 16-bit big-endian length, a command byte,
// length-1 payload bytes, a checksum byte and the footer DD EE FF, then
// emits one result per payload byte (or one empty result) with the
// command, payload count and checksum verdict.
// ----------------------------------------------------------------------------
// Timing: while a frame is being received the input is ready for every
// byte. After the last footer byte the input is held off while the results
// go out: each payload result takes a payload buffer read (S_RD) and then
// an output state (S_OUT) that holds through any output stall; the
// empty-frame result takes the output state only. The next byte is read
// only after the current result is taken. No clearing pass after reset.
module sensor_frame_deframer_core #(
  parameter int unsigned MAX_PAYLOAD = sfd_pkg::MaxPayloadDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    command_code_o,
  output logic [sfd_pkg::CountW-1:0]    payload_count_o,
  output logic [sfd_pkg::IndexW-1:0]    byte_index_o,
  output logic [7:0]                    payload_byte_o,
  output logic                          byte_present_o,
  output logic [7:0]                    received_checksum_o,
  output logic                          checksum_ok_o,
  output logic                          last_o
);
  import sfd_pkg::*;

  cmd_t    cmd;
  status_t status;

  sfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sfd_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .rx_byte_i           (rx_byte_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .command_code_o      (command_code_o),
    .payload_count_o     (payload_count_o),
    .byte_index_o        (byte_index_o),
    .payload_byte_o      (payload_byte_o),
    .byte_present_o      (byte_present_o),
    .received_checksum_o (received_checksum_o),
    .checksum_ok_o       (checksum_ok_o)
  );

  assign last_o = status.out_last;

endmodule

### rtl/core/sfd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module sfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_ctrl: deframer controller
// Walks header, length, command, payload, checksum and footer, then
// sequences the result burst out of the payload buffer.
// ----------------------------------------------------------------------------
module sfd_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  sfd_pkg::status_t status_i,
  output sfd_pkg::cmd_t    cmd_o
);
  import sfd_pkg::*;

  state_e state_q, state_d;
  logic   in_acc;

  assign in_ready_o  = (state_q != S_RD) && (state_q != S_OUT);
  assign out_valid_o = (state_q == S_OUT);
  assign in_acc      = in_valid_i && in_ready_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_H0;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_H0: begin
        if (in_acc && status_i.is_ff) state_d = S_H1;
      end
      S_H1: begin
        if (in_acc) state_d = status_i.is_ee ? S_H2 : S_H0;
      end
      S_H2: begin
        if (in_acc) state_d = status_i.is_dd ? S_LEN_HI : S_H0;
      end
      S_LEN_HI: begin
        if (in_acc) begin
          cmd_o.len_hi_load = 1'b1;
          state_d           = S_LEN_LO;
        end
      end
      S_LEN_LO: begin
        if (in_acc) begin
          cmd_o.len_lo_load = 1'b1;
          state_d           = status_i.len_ok ? S_CMD : S_H0;
        end
      end
      S_CMD: begin
        if (in_acc) begin
          cmd_o.cmd_load = 1'b1;
          state_d        = status_i.count_zero ? S_CSUM : S_PAYLOAD;
        end
      end
      S_PAYLOAD: begin
        if (in_acc) begin
          cmd_o.pay_write = 1'b1;
          if (status_i.pay_done) state_d = S_CSUM;
        end
      end
      S_CSUM: begin
        if (in_acc) begin
          cmd_o.csum_load = 1'b1;
          state_d         = S_F0;
        end
      end
      S_F0: begin
        if (in_acc) state_d = status_i.is_dd ? S_F1 : S_H0;
      end
      S_F1: begin
        if (in_acc) state_d = status_i.is_ee ? S_F2 : S_H0;
      end
      S_F2: begin
        if (in_acc) begin
          if (status_i.is_ff) begin
            cmd_o.rd_clear = 1'b1;
            state_d        = status_i.count_zero ? S_OUT : S_RD;
          end else begin
            state_d = S_H0;
          end
        end
      end
      // Fetch one buffered payload byte
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_OUT;
      end
      // Hold the result until taken
      S_OUT: begin
        if (out_ready_i) begin
          if (status_i.out_last) begin
            state_d = S_H0;
          end else begin
            cmd_o.rd_advance = 1'b1;
            state_d          = S_RD;
          end
        end
      end
      default: begin
        state_d = S_H0;
      end
    endcase
  end

endmodule

### rtl/core/sfd_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_dpath: deframer datapath
// Length check, command and checksum holding, running sum, payload buffer
// and the result fields.
// ----------------------------------------------------------------------------
module sfd_dpath #(
  parameter int unsigned MAX_PAYLOAD = sfd_pkg::MaxPayloadDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [7:0]                    rx_byte_i,
  input  sfd_pkg::cmd_t                 cmd_i,
  output sfd_pkg::status_t              status_o,
  output logic [7:0]                    command_code_o,
  output logic [sfd_pkg::CountW-1:0]    payload_count_o,
  output logic [sfd_pkg::IndexW-1:0]    byte_index_o,
  output logic [7:0]                    payload_byte_o,
  output logic                          byte_present_o,
  output logic [7:0]                    received_checksum_o,
  output logic                          checksum_ok_o
);
  import sfd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [8:0]  LenMax = 9'(MAX_PAYLOAD + 1);

  logic          len_hi_zero_q;
  logic [CW-1:0] count_q;
  logic [7:0]    cmd_q;
  logic [7:0]    sum_q;
  logic [7:0]    csum_q;
  logic [CW-1:0] wr_idx_q;
  logic [CW-1:0] rd_idx_q;
  logic [CW:0]   wr_next;
  logic [CW:0]   rd_next;
  logic [7:0]    lo_m1;
  logic [7:0]    rdata;
  logic [CW+CountW-1:0] count_ext;
  logic [CW+IndexW-1:0] index_ext;

  assign lo_m1   = rx_byte_i - 8'd1;
  assign wr_next = {1'b0, wr_idx_q} + 1'b1;
  assign rd_next = {1'b0, rd_idx_q} + 1'b1;

  // Status toward the controller
  always_comb begin
    status_o.is_ff      = (rx_byte_i == Hdr0);
    status_o.is_ee      = (rx_byte_i == Hdr1);
    status_o.is_dd      = (rx_byte_i == Hdr2);
    status_o.len_ok     = len_hi_zero_q && (rx_byte_i != 8'd0) &&
                          ({1'b0, rx_byte_i} <= LenMax);
    status_o.count_zero = (count_q == '0);
    status_o.pay_done   = (wr_next == {1'b0, count_q});
    status_o.out_last   = (count_q == '0) || (rd_next == {1'b0, count_q});
  end

  // Length, command, checksum and running sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_hi_zero_q <= 1'b0;
      count_q       <= '0;
      cmd_q         <= '0;
      sum_q         <= '0;
      csum_q        <= '0;
      wr_idx_q      <= '0;
      rd_idx_q      <= '0;
    end else begin
      if (cmd_i.len_hi_load) len_hi_zero_q <= (rx_byte_i == 8'd0);
      // loaded on every length byte but only used when the length check passes, so the low bits suffice
      if (cmd_i.len_lo_load) count_q <= lo_m1[CW-1:0];
      if (cmd_i.cmd_load) begin
        cmd_q    <= rx_byte_i;
        sum_q    <= rx_byte_i;
        wr_idx_q <= '0;
      end
      if (cmd_i.pay_write) begin
        sum_q    <= sum_q + rx_byte_i;
        wr_idx_q <= wr_next[CW-1:0];
      end
      if (cmd_i.csum_load)  csum_q   <= rx_byte_i;
      if (cmd_i.rd_clear)   rd_idx_q <= '0;
      if (cmd_i.rd_advance) rd_idx_q <= rd_next[CW-1:0];
    end
  end

  // Payload buffer
  sfd_ram #(
    .WIDTH (8),
    .DEPTH (MAX_PAYLOAD)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pay_write),
    .waddr_i (wr_idx_q[AW-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (rd_idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Result fields, masked to the port widths
  assign count_ext = {{CountW{1'b0}}, count_q};
  assign index_ext = {{IndexW{1'b0}}, rd_idx_q};

  assign command_code_o      = cmd_q;
  assign payload_count_o     = count_ext[CountW-1:0];
  assign byte_index_o        = index_ext[IndexW-1:0];
  assign byte_present_o      = (count_q != '0);
  assign payload_byte_o      = byte_present_o ? rdata : 8'd0;
  assign received_checksum_o = csum_q;
  assign checksum_ok_o       = (sum_q == csum_q);

endmodule

### rtl/core/sfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker: port-level checks for the frame deframer
// Watches the top-level ports only; attached by bind below.
// ----------------------------------------------------------------------------
module sfd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] command_code_o,
  input logic [5:0] payload_count_o,
  input logic [4:0] byte_index_o,
  input logic [7:0] payload_byte_o,
  input logic       byte_present_o,
  input logic       last_o
);

  // Input is held off while a result burst is in progress
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while a result is pending");

  // A stalled result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_code_o) &&
    $stable(byte_index_o) && $stable(payload_byte_o) && $stable(last_o))
    else $error("stalled result changed");

  // The empty-frame result is a lone, zeroed last result
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_present_o |-> last_o && payload_byte_o == 8'd0 &&
    byte_index_o == 5'd0 && payload_count_o == 6'd0)
    else $error("malformed empty-frame result");

  // A burst continues without taking input until its last result
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> !in_ready_o)
    else $error("input resumed in the middle of a burst");

endmodule

bind sensor_frame_deframer_core sfd_checker u_sfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .command_code_o  (command_code_o),
  .payload_count_o (payload_count_o),
  .byte_index_o    (byte_index_o),
  .payload_byte_o  (payload_byte_o),
  .byte_present_o  (byte_present_o),
  .last_o          (last_o)
);

### sim/sensor_frame_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_frame_deframer_core_tb: self-checking bench for the frame deframer
// Feeds received bytes: a table of hand-built frames first, then random
// frames, broken frames and line noise. A built-in deframer model predicts
// every result but those of table rows that give their own. Both handshake sides idle at random, and one long output
// stall backs the block up into its input.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_core_tb;
  import sfd_pkg::*;

  localparam int unsigned MaxPay   = MaxPayloadDef;
  localparam int unsigned HoldLen  = 300;
  localparam int unsigned SettleCy = 80;

  typedef struct packed {
    logic [7:0]        cmd;
    logic [CountW-1:0] count;
    logic [IndexW-1:0] idx;
    logic [7:0]        data;
    logic              present;
    logic [7:0]        csum;
    logic              ok;
    logic              last;
  } deframe_result_t;

  localparam deframe_result_t NoResult = '0;

  typedef enum int { FK_GOOD, FK_BAD_HDR, FK_BAD_FTR, FK_NOISE } frame_kind_e;

  // One received byte waiting to be sent, with the table expectation it closes
  typedef struct {
    logic [7:0]      data;
    bit              from_table;
    bit              row_end;
    int              n_typed;
    deframe_result_t typed_res;
  } rx_entry_t;

  // Directed row: n_typed < 0 means the model supplies the results
  typedef struct {
    frame_kind_e     kind;
    int unsigned     len;
    logic [7:0]      cmd;
    logic [7:0]      sum_delta;
    int              fault;
    int              n_typed;
    deframe_result_t res;
  } frame_row_t;

  localparam int NumRows = 8;

  frame_row_t directed_rows [NumRows] = '{
    // empty frame straight after reset, checksum good
    '{FK_GOOD, 1, 8'h00, 8'h00, 0, 1,
      '{8'h00, 6'd0, 5'd0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1}},
    // empty frame, checksum off by one
    '{FK_GOOD, 1, 8'hFF, 8'h01, 0, 1,
      '{8'hFF, 6'd0, 5'd0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1}},
    '{FK_GOOD, 33, 8'hFF, 8'h00, 0, -1, NoResult},    // full buffer
    '{FK_GOOD, 34, 8'h12, 8'h00, 0, 0, NoResult},     // one byte too long
    '{FK_GOOD, 0, 8'h13, 8'h00, 0, 0, NoResult},      // zero length
    '{FK_GOOD, 257, 8'h14, 8'h00, 0, 0, NoResult},    // high length byte set
    '{FK_BAD_HDR, 1, 8'h21, 8'h00, 1, 0, NoResult},   // FF FF EE DD: no restart
    '{FK_BAD_FTR, 1, 8'h44, 8'h00, 2, 0, NoResult}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = '0;
  logic       out_ready = 1'b0;

  logic              in_ready;
  logic              out_valid;
  logic [7:0]        command_code;
  logic [CountW-1:0] payload_count;
  logic [IndexW-1:0] byte_index;
  logic [7:0]        payload_byte;
  logic              byte_present;
  logic [7:0]        received_checksum;
  logic              checksum_ok;
  logic              last;

  rx_entry_t       rx_fifo [$];
  deframe_result_t pending_results [$];

  int unsigned fault_count = 0;
  int unsigned bytes_accepted = 0;
  int unsigned results_predicted = 0;
  int unsigned results_checked = 0;
  int unsigned frames_built = 0;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit long_hold = 1'b0;

  // Model state
  state_e      fr_phase = S_H0;
  logic [15:0] fr_len = '0;
  logic [7:0]  fr_cmd = '0;
  logic [7:0]  fr_sum = '0;
  logic [7:0]  fr_csum = '0;
  int unsigned fr_cnt = 0;
  logic [7:0]  fr_store [MaxPay];

  sensor_frame_deframer_core DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready),
    .rx_byte_i           (rx_byte),
    .out_valid_o         (out_valid),
    .out_ready_i         (out_ready),
    .command_code_o      (command_code),
    .payload_count_o     (payload_count),
    .byte_index_o        (byte_index),
    .payload_byte_o      (payload_byte),
    .byte_present_o      (byte_present),
    .received_checksum_o (received_checksum),
    .checksum_ok_o       (checksum_ok),
    .last_o              (last)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Deframer model: advance by one byte, queue any results of a closed frame
  task automatic deframe_step(input logic [7:0] b, input bit record);
    int unsigned count;
    int unsigned n;
    deframe_result_t r;
    count = (fr_len > 0) ? int'(fr_len) - 1 : 0;
    case (fr_phase)
      S_H0: fr_phase = (b == Hdr0) ? S_H1 : S_H0;
      S_H1: fr_phase = (b == Hdr1) ? S_H2 : S_H0;
      S_H2: fr_phase = (b == Hdr2) ? S_LEN_HI : S_H0;
      S_LEN_HI: begin
        fr_len   = {b, 8'h00};
        fr_phase = S_LEN_LO;
      end
      S_LEN_LO: begin
        fr_len = {fr_len[15:8], b};
        if (fr_len == 0 || int'(fr_len) - 1 > int'(MaxPay)) fr_phase = S_H0;
        else fr_phase = S_CMD;
      end
      S_CMD: begin
        fr_cmd   = b;
        fr_sum   = b;
        fr_cnt   = 0;
        fr_phase = (count == 0) ? S_CSUM : S_PAYLOAD;
      end
      S_PAYLOAD: begin
        if (fr_cnt < MaxPay) fr_store[fr_cnt] = b;
        fr_sum = fr_sum + b;
        fr_cnt++;
        if (fr_cnt >= count) fr_phase = S_CSUM;
      end
      S_CSUM: begin
        fr_csum  = b;
        fr_phase = S_F0;
      end
      S_F0: fr_phase = (b == Ftr0) ? S_F1 : S_H0;
      S_F1: fr_phase = (b == Ftr1) ? S_F2 : S_H0;
      S_F2: begin
        if (b == Ftr2) begin
          // empty frame still yields one result
          n = (count == 0) ? 1 : ((count < MaxPay) ? count : MaxPay);
          for (int unsigned i = 0; i < n; i++) begin
            r.cmd     = fr_cmd;
            r.count   = CountW'(count);
            r.idx     = IndexW'(i);
            r.data    = (count == 0) ? 8'h00 : fr_store[i];
            r.present = (count != 0);
            r.csum    = fr_csum;
            r.ok      = (fr_sum == fr_csum);
            r.last    = (i + 1 == n);
            results_predicted++;
            if (record) pending_results.push_back(r);
          end
        end
        fr_phase = S_H0;
      end
      default: fr_phase = S_H0;
    endcase
  endtask

  // Build the byte stream of one frame (or a broken one) and queue it
  task automatic queue_frame(input frame_kind_e kind, input int unsigned len,
                             input logic [7:0] cmd, input logic [7:0] sum_delta,
                             input int fault, input bit random_body,
                             input bit from_table, input int n_typed,
                             input deframe_result_t typed_res);
    logic [7:0] seq [$];
    logic [7:0] hdr [3] = '{Hdr0, Hdr1, Hdr2};
    logic [7:0] ftr [3] = '{Ftr0, Ftr1, Ftr2};
    logic [7:0] mask;
    logic [7:0] sum;
    logic [7:0] d;
    rx_entry_t  e;
    // command and body bytes of table broken-header rows stay below 0x80 so they never look like a header
    mask = (kind == FK_BAD_HDR && !random_body) ? 8'h7F : 8'hFF;
    if (kind == FK_NOISE) begin
      for (int unsigned i = 0; i < len; i++) seq.push_back(8'($urandom));
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (kind == FK_BAD_HDR && i == fault) seq.push_back((fault == 1) ? Hdr0 : 8'h00);
        seq.push_back(hdr[i]);
      end
      seq.push_back(8'(len >> 8));
      seq.push_back(8'(len));
      if (len >= 1 && len - 1 <= MaxPay) begin
        sum = cmd & mask;
        seq.push_back(sum);
        for (int unsigned i = 0; i + 1 < len; i++) begin
          d = random_body ? 8'($urandom) : (8'(i * 29 + 8'h3C) & mask);
          sum = sum + d;
          seq.push_back(d);
        end
        seq.push_back(sum + sum_delta);
        for (int i = 0; i < 3; i++) begin
          if (kind == FK_BAD_FTR && i == fault) begin
            seq.push_back((fault == 0) ? 8'hFF : 8'h00);
            break;
          end
          seq.push_back(ftr[i]);
        end
      end
      // a zero byte puts the hunt back at the first header byte
      if (kind != FK_GOOD) seq.push_back(8'h00);
    end
    foreach (seq[i]) begin
      e.data       = seq[i];
      e.from_table = from_table;
      e.row_end    = (i == seq.size() - 1);
      e.n_typed    = n_typed;
      e.typed_res  = typed_res;
      rx_fifo.push_back(e);
    end
    frames_built++;
  endtask

  task automatic queue_random_frame();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  delta;
    pick  = $urandom_range(0, 99);
    delta = ($urandom_range(0, 9) < 7) ? 8'h00 : 8'($urandom_range(1, 255));
    if (pick < 70) begin
      len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(9, MaxPay + 1);
      queue_frame(FK_GOOD, len, 8'($urandom), delta, 0, 1, 0, -1, NoResult);
    end else if (pick < 76) begin
      case ($urandom_range(0, 2))
        0:       len = 0;
        1:       len = MaxPay + 2;
        default: len = $urandom_range(MaxPay + 2, 65535);
      endcase
      queue_frame(FK_GOOD, len, 8'($urandom), delta, 0, 1, 0, -1, NoResult);
    end else if (pick < 84) begin
      queue_frame(FK_BAD_HDR, $urandom_range(1, 6), 8'($urandom), delta,
                  $urandom_range(1, 2), 1, 0, -1, NoResult);
    end else if (pick < 92) begin
      queue_frame(FK_BAD_FTR, $urandom_range(1, 6), 8'($urandom), delta,
                  $urandom_range(0, 2), 1, 0, -1, NoResult);
    end else begin
      queue_frame(FK_NOISE, $urandom_range(1, 6), 8'h00, 8'h00, 0, 1, 0, -1, NoResult);
    end
  endtask

  task automatic wait_drained();
    while (rx_fifo.size() != 0 || pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Request side: one request carries one received byte
  always @(posedge clk_i) begin : rx_driver
    rx_entry_t cur;
    logic      nxt;
    bit        bursty;
    int        gap;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      bursty = 1'b1;
      gap    = 0;
    end else begin
      nxt = in_valid;
      if ($urandom_range(0, 39) == 0) bursty = !bursty;
      if (in_valid && in_ready) begin
        cur = rx_fifo.pop_front();
        bytes_accepted++;
        // table rows with typed results skip the model's prediction
        deframe_step(cur.data, !cur.from_table || cur.n_typed < 0);
        if (cur.from_table && cur.row_end && cur.n_typed == 1)
          pending_results.push_back(cur.typed_res);
        nxt = 1'b0;
      end
      if (!nxt) begin
        if (gap > 0) begin
          gap--;
        end else if (!calm && bursty && $urandom_range(0, 5) == 0) begin
          gap = $urandom_range(0, 4);
        end else if (rx_fifo.size() > 0) begin
          nxt = 1'b1;
          rx_byte <= rx_fifo[0].data;
        end
      end
      in_valid <= nxt;
    end
  end

  // Result side ready, with random stall bursts
  always @(posedge clk_i) begin : result_ready
    bit bursty;
    int gap;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      bursty = 1'b1;
      gap    = 0;
    end else begin
      if ($urandom_range(0, 49) == 0) bursty = !bursty;
      if (long_hold) begin
        out_ready <= 1'b0;
      end else if (calm || !bursty) begin
        out_ready <= 1'b1;
      end else if (gap > 0) begin
        gap--;
        out_ready <= 1'b0;
      end else if ($urandom_range(0, 4) == 0) begin
        gap = $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Long output hold-off, counted here so the sender keeps pushing bytes
  initial begin
    wait (hold_req);
    @(posedge clk_i);
    long_hold <= 1'b1;
    for (int unsigned c = 0; c < HoldLen; c++) @(posedge clk_i);
    long_hold <= 1'b0;
  end

  // Compare each delivered result against the oldest prediction
  always @(posedge clk_i) begin : result_check
    deframe_result_t want;
    if (rst_ni && out_valid && out_ready) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("%0t: unexpected result cmd=%h idx=%0d data=%h", $time,
                   command_code, byte_index, payload_byte);
      end else begin
        want = pending_results.pop_front();
        check_field("command_code", want.cmd, command_code);
        check_field("payload_count", want.count, payload_count);
        check_field("byte_index", want.idx, byte_index);
        check_field("payload_byte", want.data, payload_byte);
        check_field("byte_present", want.present, byte_present);
        check_field("received_checksum", want.csum, received_checksum);
        check_field("checksum_ok", want.ok, checksum_ok);
        check_field("last", want.last, last);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned base_bytes;
    int unsigned base_results;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // hand-built frames
    foreach (directed_rows[i])
      queue_frame(directed_rows[i].kind, directed_rows[i].len, directed_rows[i].cmd,
                  directed_rows[i].sum_delta, directed_rows[i].fault, 0, 1,
                  directed_rows[i].n_typed, directed_rows[i].res);
    wait_drained();

    // back the block up behind a stalled output
    hold_req = 1'b1;
    queue_frame(FK_GOOD, 2, 8'h7E, 8'h00, 0, 1, 0, -1, NoResult);
    queue_frame(FK_GOOD, 1, 8'h01, 8'h09, 0, 1, 0, -1, NoResult);
    wait_drained();

    // random frames, broken frames and noise
    base_bytes   = bytes_accepted;
    base_results = results_predicted;
    while (bytes_accepted - base_bytes < 20 || results_predicted - base_results < 4) begin
      queue_random_frame();
      while (rx_fifo.size() > 6) @(posedge clk_i);
    end
    wait_drained();

    // closing stretch at full rate
    calm = 1'b1;
    repeat (2) queue_frame(FK_GOOD, $urandom_range(1, 3), 8'($urandom),
                           8'h00, 0, 1, 0, -1, NoResult);
    wait_drained();
    repeat (SettleCy) @(posedge clk_i);

    if (pending_results.size() != 0) fault_count++;
    $display("Covered %0d frames in %0d bytes, %0d results checked,", frames_built,
             bytes_accepted, results_checked);
    $display("including empty, full, oversized and broken frames and a long output stall.");
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/sfd_pkg.sv
rtl/core/sfd_ram.sv
rtl/core/sfd_ctrl.sv
rtl/core/sfd_dpath.sv
rtl/core/sensor_frame_deframer_core.sv
rtl/core/sfd_checker.sv
sim/sensor_frame_deframer_core_tb.sv
